FILE: rtl/oist_pkg.sv
`default_nettype none
package oist_pkg;

  localparam int unsigned SetCapacity = 64;
  localparam int unsigned IDX_W = $clog2(SetCapacity);
  localparam int unsigned CNT_W = $clog2(SetCapacity + 1);
  localparam int unsigned VAL_W = 32;
  localparam int unsigned KIND_W = 2;
  localparam int unsigned COUNT_OUT_W = 7;

  localparam logic [KIND_W-1:0] KIND_ADD      = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REMOVE   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CONTAINS = 2'd2;
  localparam logic [KIND_W-1:0] KIND_CLEAR    = 2'd3;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic load;   // cell at the fill position takes the request value
    logic shift;  // cells at or above the match position take their upper neighbor
  } cell_ctl_t;

endpackage
`default_nettype wire

FILE: rtl/oist_cell.sv
`default_nettype none
module oist_cell (
  input  wire logic                          clk,
  input  wire logic [oist_pkg::IDX_W-1:0]    idx_i,
  input  wire logic [oist_pkg::CNT_W-1:0]    count_i,
  input  wire logic [oist_pkg::VAL_W-1:0]    value_i,
  input  wire oist_pkg::cell_ctl_t           ctl_i,
  input  wire logic [oist_pkg::IDX_W-1:0]    pos_i,
  input  wire logic [oist_pkg::VAL_W-1:0]    nbr_i,
  output logic      [oist_pkg::VAL_W-1:0]    data_o,
  output logic                               match_o
);

  logic [oist_pkg::VAL_W-1:0] data_r;
  logic [oist_pkg::VAL_W-1:0] data_nxt;
  logic [oist_pkg::CNT_W-1:0] idx_ext;
  logic                       valid;

  assign idx_ext = oist_pkg::CNT_W'(idx_i);
  assign valid   = (idx_ext < count_i);
  assign match_o = valid && (data_r == value_i);
  assign data_o  = data_r;

  always_comb begin
    data_nxt = data_r;
    if (ctl_i.load && (idx_ext == count_i)) begin
      data_nxt = value_i;
    end else if (ctl_i.shift && (idx_i >= pos_i)) begin
      data_nxt = nbr_i;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule
`default_nettype wire

FILE: rtl/ordered_integer_set_table_unit.sv
`default_nettype none
// a request passes a compare step, then an update step that writes its result to the output register
// the update step waits while an untaken result holds that register; a new request is taken only in idle
// a new request is taken while the previous result still waits on the output register
// reset (rst_n low, synchronous): empty set, no pending request or result; cell contents
// are left as they are and never read before being written
module ordered_integer_set_table_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] value
  input  wire logic [1:0]  in_tuser,   // [1:0] kind
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata   // [0] hit, [1] full_res, [8:2] count, [15:9] zero
);

  localparam int unsigned CAP = oist_pkg::SetCapacity;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_APPLY
  } state_t;

  state_t                          state_r;
  logic [oist_pkg::KIND_W-1:0]     kind_r;
  logic [oist_pkg::VAL_W-1:0]      value_r;
  logic [oist_pkg::CNT_W-1:0]      count_r;
  logic [oist_pkg::CNT_W-1:0]      count_nxt;
  logic [oist_pkg::IDX_W-1:0]      pos_r;
  logic [oist_pkg::IDX_W-1:0]      pos_nxt;
  logic                            any_r;
  logic                            out_valid_r;
  logic                            hit_r;
  logic                            hit_nxt;
  logic                            full_r;
  logic                            full_nxt;
  oist_pkg::cell_ctl_t             ctl;

  logic [CAP-1:0]                  match;
  logic [oist_pkg::VAL_W-1:0]      cell_data [CAP];
  logic [31:0]                     count_ext;

  // row of cells; on a remove, cells at or above the match take their upper neighbor's value (top keeps its own)
  for (genvar i = 0; i < CAP; i++) begin : g_cell
    logic [oist_pkg::VAL_W-1:0] nbr;
    if (i == CAP - 1) begin : g_top
      assign nbr = cell_data[i];
    end else begin : g_mid
      assign nbr = cell_data[i+1];
    end
    oist_cell u_cell (
      .clk     (clk),
      .idx_i   (oist_pkg::IDX_W'(i)),
      .count_i (count_r),
      .value_i (value_r),
      .ctl_i   (ctl),
      .pos_i   (pos_r),
      .nbr_i   (nbr),
      .data_o  (cell_data[i]),
      .match_o (match[i])
    );
  end

  // set entries are distinct, so at most one match: or-encode its position
  always_comb begin
    pos_nxt = '0;
    for (int i = 0; i < CAP; i++) begin
      if (match[i]) begin
        pos_nxt = pos_nxt | oist_pkg::IDX_W'(i);
      end
    end
  end

  wire apply_go  = (state_r == S_APPLY) && (!out_valid_r || out_tready);
  wire has_room  = (count_r < oist_pkg::CNT_W'(CAP));

  always_comb begin
    ctl = '0;
    if (apply_go) begin
      ctl.load  = (kind_r == oist_pkg::KIND_ADD) && !any_r && has_room;
      ctl.shift = (kind_r == oist_pkg::KIND_REMOVE) && any_r;
    end
  end

  // result flags and new count for the request in the apply step
  always_comb begin
    hit_nxt   = 1'b0;
    full_nxt  = 1'b0;
    count_nxt = count_r;
    case (kind_r)
      oist_pkg::KIND_ADD: begin
        if (!any_r) begin
          if (has_room) begin
            count_nxt = count_r + oist_pkg::CNT_W'(1);
            hit_nxt   = 1'b1;
          end else begin
            full_nxt  = 1'b1;
          end
        end
      end
      oist_pkg::KIND_REMOVE: begin
        if (any_r) begin
          count_nxt = count_r - oist_pkg::CNT_W'(1);
          hit_nxt   = 1'b1;
        end
      end
      oist_pkg::KIND_CONTAINS: begin
        hit_nxt = any_r;
      end
      default: begin
        count_nxt = '0;
      end
    endcase
  end

  assign in_tready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      any_r       <= 1'b0;
    end else begin
      // a new result replaces the one leaving in the same cycle
      if (apply_go) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            kind_r  <= in_tuser;
            value_r <= in_tdata;
            state_r <= S_LOOK;
          end
        end
        S_LOOK: begin
          any_r   <= |match;
          pos_r   <= pos_nxt;
          state_r <= S_APPLY;
        end
        S_APPLY: begin
          if (apply_go) begin
            hit_r   <= hit_nxt;
            full_r  <= full_nxt;
            count_r <= count_nxt;
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // count goes out as its low seven bits
  assign count_ext  = 32'(count_r);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, count_ext[oist_pkg::COUNT_OUT_W-1:0], full_r, hit_r};

endmodule
`default_nettype wire
